// File: hw/rtl/rtp_pkg.sv
// ----------------------------------------------------------------------------
// rtp_pkg
// Shared types and constants for the transport parameter derivation pipeline.
// ----------------------------------------------------------------------------
package rtp_pkg;

    localparam int DIV_W      = 48;
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = DIV_W / DIV_STEPS;
    localparam int ND         = 7;

    localparam int IN_W  = 128;
    localparam int OUT_W = 232;

    localparam logic [13:0] KMAX_SYMBOLS = 14'd8192;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ALIGN = 2'd1,
        ST_BIG   = 2'd2,
        ST_ZERO  = 2'd3
    } t_status;

    typedef struct packed {
        t_status     status;
        logic [7:0]  al;
        logic [13:0] kmin;
        logic [7:0]  gmax;
        logic [15:0] p;
        logic [44:0] f;
        logic [31:0] w;
        logic [15:0] pa;
        logic [7:0]  g;
        logic [15:0] t;
        logic [15:0] units;
        logic [44:0] kt;
        logic [32:0] z;
        logic [13:0] kl;
        logic [13:0] ks;
        logic [31:0] zl;
        logic [15:0] n;
    } t_ctx;

endpackage

// File: hw/rtl/rtp_div.sv
// ----------------------------------------------------------------------------
// rtp_div
// Pipelined restoring divider, 48-bit numerator and divisor, four quotient
// bits per stage, with a context word carried alongside.
// ----------------------------------------------------------------------------
module rtp_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  rtp_pkg::t_ctx              i_ctx,
    input  logic [rtp_pkg::DIV_W-1:0]  i_num,
    input  logic [rtp_pkg::DIV_W-1:0]  i_den,
    output logic                       o_valid,
    input  logic                       i_ready,
    output rtp_pkg::t_ctx              o_ctx,
    output logic [rtp_pkg::DIV_W-1:0]  o_quo,
    output logic [rtp_pkg::DIV_W-1:0]  o_rem
);
    import rtp_pkg::*;

    logic               r_v   [0:DIV_STAGES];
    t_ctx               r_ctx [0:DIV_STAGES];
    logic [DIV_W-1:0]   r_rem [0:DIV_STAGES];
    logic [DIV_W-1:0]   r_nq  [0:DIV_STAGES];
    logic [DIV_W-1:0]   r_den [0:DIV_STAGES];
    logic               ld    [0:DIV_STAGES+1];

    assign ld[DIV_STAGES+1] = i_ready;

    for (genvar k = 0; k <= DIV_STAGES; k++) begin : g_st
        logic               n_v;
        t_ctx               n_ctx;
        logic [DIV_W-1:0]   n_rem;
        logic [DIV_W-1:0]   n_nq;
        logic [DIV_W-1:0]   n_den;

        assign ld[k] = ~r_v[k] | ld[k+1];

        if (k == 0) begin : g_in
            assign n_v   = i_valid;
            assign n_ctx = i_ctx;
            assign n_rem = '0;
            assign n_nq  = i_num;
            assign n_den = i_den;
        end else begin : g_step
            logic [DIV_W:0] s_t;
            assign n_v   = r_v[k-1];
            assign n_ctx = r_ctx[k-1];
            assign n_den = r_den[k-1];
            always_comb begin
                n_rem = r_rem[k-1];
                n_nq  = r_nq[k-1];
                s_t   = '0;
                for (int j = 0; j < DIV_STEPS; j++) begin
                    s_t  = {n_rem, n_nq[DIV_W-1]};
                    n_nq = {n_nq[DIV_W-2:0], 1'b0};
                    if (s_t >= {1'b0, n_den}) begin
                        s_t     = s_t - {1'b0, n_den};
                        n_nq[0] = 1'b1;
                    end
                    n_rem = s_t[DIV_W-1:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (ld[k]) begin
                r_v[k] <= n_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (ld[k]) begin
                r_ctx[k] <= n_ctx;
                r_rem[k] <= n_rem;
                r_nq[k]  <= n_nq;
                r_den[k] <= n_den;
            end
        end
    end

    assign o_ready = ld[0];
    assign o_valid = r_v[DIV_STAGES];
    assign o_ctx   = r_ctx[DIV_STAGES];
    assign o_quo   = r_nq[DIV_STAGES];
    assign o_rem   = r_rem[DIV_STAGES];

endmodule

// File: hw/rtl/raptor_transport_param_derive.sv
// ----------------------------------------------------------------------------
// raptor_transport_param_derive
// Derives Raptor code transport parameters and block/sub-block partitions.
// ----------------------------------------------------------------------------
// One word in, one word out per cycle while the output is not stalled. Seven chained
// 48-bit restoring dividers of 13 register stages each (an input register, then
// four quotient bits per stage) make up the whole pipeline. A stalled output fills
// the pipeline bubbles before the input side stalls. Nonzero status zeroes all
// other result fields.
module raptor_transport_param_derive (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    // align_bytes, min_symbols, max_group, payload_size, transfer_length,
    // work_memory, zero pad
    input  logic [rtp_pkg::IN_W-1:0]     i_s_tdata,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    // status, group_size, symbol_size, total_symbols, block_count,
    // subblock_count, large_block_symbols, small_block_symbols,
    // large_block_count, large_sub_units, small_sub_units, large_sub_count, pad
    output logic [rtp_pkg::OUT_W-1:0]    o_m_tdata
);
    import rtp_pkg::*;

    logic             dv_in  [0:ND-1];
    logic             dr_in  [0:ND-1];
    t_ctx             dc_in  [0:ND-1];
    logic [DIV_W-1:0] dn_in  [0:ND-1];
    logic [DIV_W-1:0] dd_in  [0:ND-1];
    logic             dv_out [0:ND-1];
    logic             dr_out [0:ND-1];
    t_ctx             dc_out [0:ND-1];
    logic [DIV_W-1:0] dq_out [0:ND-1];
    logic [DIV_W-1:0] dm_out [0:ND-1];

    for (genvar i = 0; i < ND; i++) begin : g_div
        rtp_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (dv_in[i]),
            .o_ready (dr_in[i]),
            .i_ctx   (dc_in[i]),
            .i_num   (dn_in[i]),
            .i_den   (dd_in[i]),
            .o_valid (dv_out[i]),
            .i_ready (dr_out[i]),
            .o_ctx   (dc_out[i]),
            .o_quo   (dq_out[i]),
            .o_rem   (dm_out[i])
        );
    end

    for (genvar i = 1; i < ND; i++) begin : g_hs
        assign dv_in[i]    = dv_out[i-1];
        assign dr_out[i-1] = dr_in[i];
    end

    assign dv_in[0]      = i_s_tvalid;
    assign o_s_tready    = dr_in[0];
    assign o_m_tvalid    = dv_out[ND-1];
    assign dr_out[ND-1]  = i_m_tready;

    // P / Al
    always_comb begin
        t_ctx c;
        c        = '0;
        c.al     = i_s_tdata[7:0];
        c.kmin   = i_s_tdata[21:8];
        c.gmax   = i_s_tdata[29:22];
        c.p      = i_s_tdata[45:30];
        c.f      = i_s_tdata[90:46];
        c.w      = i_s_tdata[122:91];
        c.status = (c.al == 8'd0) ? ST_ZERO : ST_OK;
        dc_in[0] = c;
        dn_in[0] = DIV_W'(c.p);
        dd_in[0] = (c.al == 8'd0) ? DIV_W'(1) : DIV_W'(c.al);
    end

    // P*Kmin / F
    always_comb begin
        t_ctx        c;
        logic [29:0] prod;
        c    = dc_out[0];
        c.pa = dq_out[0][15:0];
        if (c.status == ST_OK) begin
            if (dm_out[0] != '0) begin
                c.status = ST_ALIGN;
            end else if (c.f == '0) begin
                c.status = ST_ZERO;
            end
        end
        prod     = c.p * c.kmin;
        dc_in[1] = c;
        dn_in[1] = DIV_W'(prod);
        dd_in[1] = (c.f == '0) ? DIV_W'(1) : DIV_W'(c.f);
    end

    // P / (Al*G)
    always_comb begin
        t_ctx             c;
        logic [DIV_W-1:0] gc;
        logic [15:0]      ag;
        c  = dc_out[1];
        gc = dq_out[1] + DIV_W'(dm_out[1] != '0);
        if (DIV_W'(c.pa) < gc) begin
            gc = DIV_W'(c.pa);
        end
        if (DIV_W'(c.gmax) < gc) begin
            gc = DIV_W'(c.gmax);
        end
        c.g = gc[7:0];
        if (c.status == ST_OK && c.g == 8'd0) begin
            c.status = ST_ZERO;
        end
        ag       = c.al * c.g;
        dc_in[2] = c;
        dn_in[2] = DIV_W'(c.p);
        dd_in[2] = (ag == 16'd0) ? DIV_W'(1) : DIV_W'(ag);
    end

    // F / T
    always_comb begin
        t_ctx        c;
        logic [23:0] tp;
        c       = dc_out[2];
        c.units = dq_out[2][15:0];
        tp      = c.units * c.al;
        c.t     = tp[15:0];
        dc_in[3] = c;
        dn_in[3] = DIV_W'(c.f);
        dd_in[3] = (c.t == 16'd0) ? DIV_W'(1) : DIV_W'(c.t);
    end

    // Kt / Z
    always_comb begin
        t_ctx             c;
        logic [DIV_W-1:0] ktw;
        c    = dc_out[3];
        ktw  = dq_out[3] + DIV_W'(dm_out[3] != '0);
        c.kt = ktw[44:0];
        c.z  = {1'b0, c.kt[44:13]} + 33'(|c.kt[12:0]);
        dc_in[4] = c;
        dn_in[4] = DIV_W'(c.kt);
        dd_in[4] = (c.z == '0) ? DIV_W'(1) : DIV_W'(c.z);
    end

    // KL*T / W
    always_comb begin
        t_ctx             c;
        logic [DIV_W-1:0] klw;
        logic [29:0]      prod;
        c    = dc_out[4];
        klw  = dq_out[4] + DIV_W'(dm_out[4] != '0);
        c.ks = dq_out[4][13:0];
        c.kl = klw[13:0];
        c.zl = dm_out[4][31:0];
        if (c.status == ST_OK) begin
            if (c.w == '0) begin
                c.status = ST_ZERO;
            end else if (klw > DIV_W'(KMAX_SYMBOLS)) begin
                c.status = ST_BIG;
            end
        end
        prod     = c.kl * c.t;
        dc_in[5] = c;
        dn_in[5] = DIV_W'(prod);
        dd_in[5] = (c.w == '0) ? DIV_W'(1) : DIV_W'(c.w);
    end

    // (T/Al) / N
    always_comb begin
        t_ctx             c;
        logic [DIV_W-1:0] nc;
        c  = dc_out[5];
        nc = dq_out[5] + DIV_W'(dm_out[5] != '0);
        c.n = (DIV_W'(c.units) < nc) ? c.units : nc[15:0];
        dc_in[6] = c;
        dn_in[6] = DIV_W'(c.units);
        dd_in[6] = (c.n == 16'd0) ? DIV_W'(1) : DIV_W'(c.n);
    end

    always_comb begin
        t_ctx        c;
        logic [15:0] ts;
        logic [15:0] tl;
        c  = dc_out[6];
        ts = dq_out[6][15:0];
        tl = ts + 16'(dm_out[6] != '0);
        o_m_tdata = '0;
        o_m_tdata[1:0] = c.status;
        if (c.status == ST_OK) begin
            o_m_tdata[9:2]     = c.g;
            o_m_tdata[25:10]   = c.t;
            o_m_tdata[70:26]   = c.kt;
            o_m_tdata[102:71]  = c.z[31:0];
            o_m_tdata[118:103] = c.n;
            o_m_tdata[132:119] = c.kl;
            o_m_tdata[146:133] = c.ks;
            o_m_tdata[178:147] = c.zl;
            o_m_tdata[194:179] = tl;
            o_m_tdata[210:195] = ts;
            o_m_tdata[226:211] = dm_out[6][15:0];
        end
    end

endmodule

// File: hw/rtl/rtp_chk.sv
// ----------------------------------------------------------------------------
// rtp_chk
// Port-level checks for raptor_transport_param_derive.
// ----------------------------------------------------------------------------
module rtp_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_s_tvalid,
    input logic                       o_s_tready,
    input logic [rtp_pkg::IN_W-1:0]   i_s_tdata,
    input logic                       o_m_tvalid,
    input logic                       i_m_tready,
    input logic [rtp_pkg::OUT_W-1:0]  o_m_tdata
);
    import rtp_pkg::*;

    logic [1:0]  st;
    logic [13:0] kl;
    logic [13:0] ks;

    assign st = o_m_tdata[1:0];
    assign kl = o_m_tdata[132:119];
    assign ks = o_m_tdata[146:133];

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && st != ST_OK |-> o_m_tdata[226:2] == '0)
        else $error("error word carries nonzero fields");

    a_ok_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && st == ST_OK |-> o_m_tdata[9:2] != '0 && o_m_tdata[25:10] != '0)
        else $error("ok word with zero group or symbol size");

    a_block_part: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && st == ST_OK |-> kl <= KMAX_SYMBOLS && (kl == ks || kl == ks + 14'd1))
        else $error("source block partition inconsistent");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled output word changed");

endmodule

bind raptor_transport_param_derive rtp_chk u_rtp_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
